/* hdl/rtbf_pkg.sv */
// Shared constants, types and helpers of the row transition band finder.
`timescale 1ns / 1ps

package rtbf_pkg;

  // Frame geometry limits.
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int SIZE_W = 11;
  localparam int PIX_W  = 8;
  localparam int CNT_W  = 10;
  localparam int DIV_W  = 4;
  localparam int ACC_W  = DIV_W + COL_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRANSITIONS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_RUN_DIVISOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_RUN_DIVISOR = 3'd4;

  localparam logic [CNT_W-1:0]  RST_MIN_TRANSITIONS    = CNT_W'(10);
  localparam logic [SIZE_W-1:0] RST_COLS_IN_USE        = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] RST_ROWS_IN_USE        = SIZE_W'(1024);
  localparam logic [DIV_W-1:0]  RST_TOP_RUN_DIVISOR    = DIV_W'(5);
  localparam logic [DIV_W-1:0]  RST_BOTTOM_RUN_DIVISOR = DIV_W'(1);

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Settings as both halves see them, with the sizes already clamped.
  typedef struct packed {
    logic [CNT_W-1:0]  min_trans;
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
    logic [DIV_W-1:0]  top_div;
    logic [DIV_W-1:0]  bot_div;
  } cfg_t;

  // One classified pixel, passed from front to back.
  typedef struct packed {
    logic             first_col;
    logic             changed;
    logic             row_end;
    logic             frame_end;
    logic [ROW_W-1:0] row;
  } tok_t;

  // Clamp a size register into the range 1 .. hi.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

/* hdl/rtbf_front.sv */
// Front half: tracks raster position and classifies each pixel.
`timescale 1ns / 1ps

module rtbf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rtbf_pkg::cfg_t             cfg,
  input  logic                       push,
  input  logic [rtbf_pkg::PIX_W-1:0] pixel,
  output rtbf_pkg::tok_t             tok
);
  import rtbf_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] prev_r, prev_nxt;
  logic             row_end, frame_end;

  assign row_end   = ({1'b0, col_r} + SIZE_W'(1)) >= cfg.cols;
  assign frame_end = row_end && (({1'b0, row_r} + SIZE_W'(1)) >= cfg.rows);

  always_comb begin
    tok.first_col = (col_r == '0);
    tok.changed   = (pixel != prev_r);
    tok.row_end   = row_end;
    tok.frame_end = frame_end;
    tok.row       = row_r;
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    prev_nxt = prev_r;
    if (push) begin
      prev_nxt = pixel;
      if (!row_end) begin
        col_nxt = col_r + COL_W'(1);
      end else begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      prev_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

/* hdl/rtbf_queue.sv */
// Short queue of classified pixels between front and back.
`timescale 1ns / 1ps

module rtbf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rtbf_pkg::tok_t push_tok,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rtbf_pkg::tok_t head
);
  import rtbf_pkg::*;

  tok_t           mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCW'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QAW'(QDEPTH - 1)) ? '0 : wptr_r + QAW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QAW'(QDEPTH - 1)) ? '0 : rptr_r + QAW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_tok;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == QCW'(QDEPTH)) |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

/* hdl/rtbf_back.sv */
// Back half: row counting, abort tests, band search and the result register.
`timescale 1ns / 1ps

module rtbf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rtbf_pkg::cfg_t             cfg,
  input  logic                       tok_valid,
  input  rtbf_pkg::tok_t             tok,
  output logic                       tok_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rtbf_pkg::ROW_W-1:0] out_top_row,
  output logic [rtbf_pkg::ROW_W-1:0] out_bottom_row,
  output logic                       out_top_found,
  output logic                       out_bottom_found,
  output logic                       out_bottom_replaced
);
  import rtbf_pkg::*;

  logic [CNT_W-1:0] cc_r, cc_nxt;
  logic [ACC_W-1:0] tacc_r, tacc_nxt;
  logic [ACC_W-1:0] bacc_r, bacc_nxt;
  logic             tab_r, tab_nxt;
  logic             bab_r, bab_nxt;
  logic             fseen_r, fseen_nxt;
  logic [ROW_W-1:0] fval_r, fval_nxt;
  logic             lseen_r, lseen_nxt;
  logic [ROW_W-1:0] lval_r, lval_nxt;

  logic             ov_r, ov_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic [ROW_W-1:0] bot_r, bot_nxt;
  logic             tf_r, tf_nxt;
  logic             bf_r, bf_nxt;
  logic             rep_r, rep_nxt;

  logic [CNT_W-1:0]  tcnt, bcnt;
  logic [ROW_W-1:0]  last_row, top_sel, bot_sel;
  logic [SIZE_W-1:0] rows_m1;

  // Only the last word of a frame needs the result register to be free.
  assign tok_pop  = tok_valid && (!tok.frame_end || !ov_r || !out_stall);
  assign rows_m1  = cfg.rows - SIZE_W'(1);
  assign last_row = rows_m1[ROW_W-1:0];

  always_comb begin
    cc_nxt    = cc_r;
    tacc_nxt  = tacc_r;
    bacc_nxt  = bacc_r;
    tab_nxt   = tab_r;
    bab_nxt   = bab_r;
    fseen_nxt = fseen_r;
    fval_nxt  = fval_r;
    lseen_nxt = lseen_r;
    lval_nxt  = lval_r;
    ov_nxt    = ov_r && out_stall;
    top_nxt   = top_r;
    bot_nxt   = bot_r;
    tf_nxt    = tf_r;
    bf_nxt    = bf_r;
    rep_nxt   = rep_r;
    tcnt      = '0;
    bcnt      = '0;
    top_sel   = '0;
    bot_sel   = '0;

    if (tok_pop) begin
      // The run products stand in for divisor times run length.
      if (!tok.first_col) begin
        if (tok.changed) begin
          cc_nxt   = cc_r + CNT_W'(1);
          tacc_nxt = '0;
          bacc_nxt = '0;
        end else begin
          tacc_nxt = tacc_r + ACC_W'(cfg.top_div);
          bacc_nxt = bacc_r + ACC_W'(cfg.bot_div);
          if (ACC_W'(cfg.cols) < tacc_nxt) begin
            tab_nxt = 1'b1;
          end
          if (ACC_W'(cfg.cols) < bacc_nxt) begin
            bab_nxt = 1'b1;
          end
        end
      end

      if (tok.row_end) begin
        tcnt = tab_nxt ? '0 : cc_nxt;
        bcnt = bab_nxt ? '0 : cc_nxt;
        if (!fseen_r && tcnt >= cfg.min_trans) begin
          fseen_nxt = 1'b1;
          fval_nxt  = tok.row;
        end
        if (tok.row != '0 && bcnt >= cfg.min_trans) begin
          lseen_nxt = 1'b1;
          lval_nxt  = tok.row;
        end
        cc_nxt   = '0;
        tacc_nxt = '0;
        bacc_nxt = '0;
        tab_nxt  = 1'b0;
        bab_nxt  = 1'b0;

        if (tok.frame_end) begin
          top_sel = fseen_nxt ? fval_nxt : last_row;
          if (lseen_nxt) begin
            bot_sel = lval_nxt;
          end else begin
            bot_sel = (cfg.rows >= SIZE_W'(2)) ? ROW_W'(1) : '0;
          end
          ov_nxt  = 1'b1;
          top_nxt = top_sel;
          tf_nxt  = fseen_nxt;
          bf_nxt  = lseen_nxt;
          if (bot_sel <= top_sel) begin
            bot_nxt = last_row;
            rep_nxt = 1'b1;
          end else begin
            bot_nxt = bot_sel;
            rep_nxt = 1'b0;
          end
          fseen_nxt = 1'b0;
          fval_nxt  = '0;
          lseen_nxt = 1'b0;
          lval_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r    <= '0;
      tacc_r  <= '0;
      bacc_r  <= '0;
      tab_r   <= 1'b0;
      bab_r   <= 1'b0;
      fseen_r <= 1'b0;
      fval_r  <= '0;
      lseen_r <= 1'b0;
      lval_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      cc_r    <= cc_nxt;
      tacc_r  <= tacc_nxt;
      bacc_r  <= bacc_nxt;
      tab_r   <= tab_nxt;
      bab_r   <= bab_nxt;
      fseen_r <= fseen_nxt;
      fval_r  <= fval_nxt;
      lseen_r <= lseen_nxt;
      lval_r  <= lval_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    bot_r <= bot_nxt;
    tf_r  <= tf_nxt;
    bf_r  <= bf_nxt;
    rep_r <= rep_nxt;
  end

  assign out_valid           = ov_r;
  assign out_top_row         = top_r;
  assign out_bottom_row      = bot_r;
  assign out_top_found       = tf_r;
  assign out_bottom_found    = bf_r;
  assign out_bottom_replaced = rep_r;

`ifndef SYNTHESIS
  a_band_order: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !rep_r) |-> (bot_r > top_r))
    else $error("bottom bound not below top bound");

  a_no_top_default: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !tf_r) |-> (top_r == last_row))
    else $error("top bound without a hit is not the last row");

  a_row_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_pop && tok.row_end) |=> (cc_r == '0 && !tab_r && !bab_r))
    else $error("row counters not cleared at row end");
`endif

endmodule

/* hdl/row_transition_band_finder.sv */
// Top level of the row transition band finder: settings, front, queue, back.
`timescale 1ns / 1ps

//  Channel  Direction  Handshake            Word
//  in_      input      in_valid/in_stall    in_pixel, one pixel in raster order
//  out_     output     out_valid/out_stall  top/bottom bounds and flags, one per frame
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The block takes one pixel per clock unless in_stall is high. A pixel word is
// classified in the front half (position in the frame and whether it differs from its
// left neighbor) and placed in a four-entry queue; the back half takes one word per
// clock from that queue unless out_stall halts it, and keeps the per-row change count
// and run tests. The result of a frame is registered in the result register when the
// back half takes its last word. in_stall rises only while the queue is full;
// out_stall holds the result register and halts the back half only when the last word
// of the next frame reaches it while a result still waits. Reset (rst_n low,
// synchronous) restores default settings, clears the frame position and all counters.

module row_transition_band_finder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rtbf_pkg::PIX_W-1:0]          in_pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rtbf_pkg::ROW_W-1:0]          out_top_row,
  output logic [rtbf_pkg::ROW_W-1:0]          out_bottom_row,
  output logic                                out_top_found,
  output logic                                out_bottom_found,
  output logic                                out_bottom_replaced,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rtbf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtbf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rtbf_pkg::*;

  // Settings registers, as written.
  logic [CNT_W-1:0]  min_trans_r, min_trans_nxt;
  logic [SIZE_W-1:0] cols_r, cols_nxt;
  logic [SIZE_W-1:0] rows_r, rows_nxt;
  logic [DIV_W-1:0]  top_div_r, top_div_nxt;
  logic [DIV_W-1:0]  bot_div_r, bot_div_nxt;

  cfg_t cfg;
  tok_t front_tok, q_head;
  logic push, pop, q_full, q_not_empty;

  // Settings are always writable; the user only writes them while idle.
  assign cfg_ready = 1'b1;

  always_comb begin
    min_trans_nxt = min_trans_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    top_div_nxt   = top_div_r;
    bot_div_nxt   = bot_div_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_TRANSITIONS:    min_trans_nxt = cfg_data[CNT_W-1:0];
        CFG_COLS_IN_USE:        cols_nxt      = cfg_data[SIZE_W-1:0];
        CFG_ROWS_IN_USE:        rows_nxt      = cfg_data[SIZE_W-1:0];
        CFG_TOP_RUN_DIVISOR:    top_div_nxt   = cfg_data[DIV_W-1:0];
        CFG_BOTTOM_RUN_DIVISOR: bot_div_nxt   = cfg_data[DIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_trans_r <= RST_MIN_TRANSITIONS;
      cols_r      <= RST_COLS_IN_USE;
      rows_r      <= RST_ROWS_IN_USE;
      top_div_r   <= RST_TOP_RUN_DIVISOR;
      bot_div_r   <= RST_BOTTOM_RUN_DIVISOR;
    end else begin
      min_trans_r <= min_trans_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      top_div_r   <= top_div_nxt;
      bot_div_r   <= bot_div_nxt;
    end
  end

  // Out-of-range sizes are pulled into 1 .. MAX before either half sees them.
  always_comb begin
    cfg.min_trans = min_trans_r;
    cfg.cols      = clamp_size(cols_r, SIZE_W'(MAX_COLS));
    cfg.rows      = clamp_size(rows_r, SIZE_W'(MAX_ROWS));
    cfg.top_div   = top_div_r;
    cfg.bot_div   = bot_div_r;
  end

  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;

  rtbf_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .push  (push),
    .pixel (in_pixel),
    .tok   (front_tok)
  );

  rtbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (front_tok),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rtbf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .tok_valid           (q_not_empty),
    .tok                 (q_head),
    .tok_pop             (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_top_row         (out_top_row),
    .out_bottom_row      (out_bottom_row),
    .out_top_found       (out_top_found),
    .out_bottom_found    (out_bottom_found),
    .out_bottom_replaced (out_bottom_replaced)
  );

endmodule

/* bench/row_transition_band_finder_tb.sv */
// Self-checking testbench of the row transition band finder.
`timescale 1ns / 1ps

module row_transition_band_finder_tb;
  import rtbf_pkg::*;

  // One frame result word, as the block should produce it.
  typedef struct packed {
    logic [ROW_W-1:0] top_row;
    logic [ROW_W-1:0] bottom_row;
    logic             top_found;
    logic             bottom_found;
    logic             bottom_replaced;
  } bounds_t;

  // Pixel textures used to build rows of random content.
  typedef enum int unsigned {ALTERNATE, TWO_LEVEL, RUNS, NOISE, FLAT} texture_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ROW_W-1:0]      out_top_row;
  logic [ROW_W-1:0]      out_bottom_row;
  logic                  out_top_found;
  logic                  out_bottom_found;
  logic                  out_bottom_replaced;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  row_transition_band_finder u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pixel            (in_pixel),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_top_row         (out_top_row),
    .out_bottom_row      (out_bottom_row),
    .out_top_found       (out_top_found),
    .out_bottom_found    (out_bottom_found),
    .out_bottom_replaced (out_bottom_replaced),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Settings as the block holds them after each accepted register write.
  logic [CNT_W-1:0]  min_changes  = RST_MIN_TRANSITIONS;
  logic [SIZE_W-1:0] cols_setting = RST_COLS_IN_USE;
  logic [SIZE_W-1:0] rows_setting = RST_ROWS_IN_USE;
  logic [DIV_W-1:0]  top_div      = RST_TOP_RUN_DIVISOR;
  logic [DIV_W-1:0]  bottom_div   = RST_BOTTOM_RUN_DIVISOR;

  // Running frame position, row counters and search results.
  logic [COL_W-1:0] col_pos = '0;
  logic [ROW_W-1:0] row_pos = '0;
  logic [PIX_W-1:0] last_pixel = '0;
  logic [CNT_W-1:0] row_changes = '0;
  logic [CNT_W-1:0] run_len = '0;
  logic             top_abort = 1'b0;
  logic             bottom_abort = 1'b0;
  logic             top_hit = 1'b0;
  logic [ROW_W-1:0] top_hit_row = '0;
  logic             bottom_hit = 1'b0;
  logic [ROW_W-1:0] bottom_hit_row = '0;

  logic [PIX_W-1:0] pending_pixels[$];
  bounds_t          expected_bounds[$];
  int unsigned      pixels_queued = 0;
  int unsigned      pixels_accepted = 0;
  int unsigned      bounds_seen = 0;
  int unsigned      mismatches = 0;

  // Sender burst shaping and receiver stall pattern.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_mode_left = 0;

  // Row and frame sizes after saturation into the supported range.
  function automatic int unsigned frame_cols();
    if (cols_setting == '0) return 1;
    if (cols_setting > MAX_COLS) return MAX_COLS;
    return cols_setting;
  endfunction

  function automatic int unsigned frame_rows();
    if (rows_setting == '0) return 1;
    if (rows_setting > MAX_ROWS) return MAX_ROWS;
    return rows_setting;
  endfunction

  // Advance both searches by one accepted pixel; at the end of a frame the
  // bounds of that frame are appended to the expected results.
  function automatic void advance_band_search(input logic [PIX_W-1:0] pix);
    int unsigned cols;
    int unsigned rows;
    int unsigned top_cnt;
    int unsigned bottom_cnt;
    int unsigned top;
    int unsigned bottom;
    bounds_t     b;
    cols = frame_cols();
    rows = frame_rows();
    if (col_pos != '0) begin
      if (pix != last_pixel) begin
        row_changes++;
        run_len = '0;
      end else begin
        run_len++;
      end
      // A long run of equal neighbors disqualifies the row for a search.
      if (run_len != '0) begin
        if (cols < top_div * int'(run_len)) top_abort = 1'b1;
        if (cols < bottom_div * int'(run_len)) bottom_abort = 1'b1;
      end
    end
    last_pixel = pix;
    if (col_pos + 1 < cols) begin
      col_pos++;
      return;
    end
    top_cnt = top_abort ? 0 : row_changes;
    bottom_cnt = bottom_abort ? 0 : row_changes;
    if (!top_hit && top_cnt >= min_changes) begin
      top_hit = 1'b1;
      top_hit_row = row_pos;
    end
    // Row zero never counts for the bottom search.
    if (row_pos >= 1 && bottom_cnt >= min_changes) begin
      bottom_hit = 1'b1;
      bottom_hit_row = row_pos;
    end
    col_pos = '0;
    row_changes = '0;
    run_len = '0;
    top_abort = 1'b0;
    bottom_abort = 1'b0;
    if (row_pos + 1 < rows) begin
      row_pos++;
      return;
    end
    top = top_hit ? top_hit_row : rows - 1;
    bottom = bottom_hit ? bottom_hit_row : ((rows >= 2) ? 1 : 0);
    b.bottom_replaced = 1'b0;
    if (bottom <= top) begin
      bottom = rows - 1;
      b.bottom_replaced = 1'b1;
    end
    b.top_row = ROW_W'(top);
    b.bottom_row = ROW_W'(bottom);
    b.top_found = top_hit;
    b.bottom_found = bottom_hit;
    expected_bounds.push_back(b);
    row_pos = '0;
    last_pixel = '0;
    top_hit = 1'b0;
    top_hit_row = '0;
    bottom_hit = 1'b0;
    bottom_hit_row = '0;
  endfunction

  // Driver: presents pending pixels in bursts separated by random gaps and
  // holds a stalled word unchanged. Each accepted word updates the searches.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_band_search(in_pixel);
        pixels_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          in_valid <= 1'b1;
          in_pixel <= pending_pixels.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Half of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: compares each accepted result word with the oldest expected
  // frame bounds, and drives out_stall from a pattern that changes mode.
  always @(posedge clk) begin
    bounds_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        bounds_seen++;
        if (expected_bounds.size() == 0) begin
          $error("result word with no frame pending: top_row %0d bottom_row %0d",
                 out_top_row, out_bottom_row);
          mismatches++;
        end else begin
          want = expected_bounds.pop_front();
          check_field("top_row", want.top_row, out_top_row);
          check_field("bottom_row", want.bottom_row, out_bottom_row);
          check_field("top_found", want.top_found, out_top_found);
          check_field("bottom_found", want.bottom_found, out_bottom_found);
          check_field("bottom_replaced", want.bottom_replaced, out_bottom_replaced);
        end
      end
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(20, 120);
      end else begin
        stall_mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MIN_TRANSITIONS:    min_changes = value[CNT_W-1:0];
      CFG_COLS_IN_USE:        cols_setting = value;
      CFG_ROWS_IN_USE:        rows_setting = value;
      CFG_TOP_RUN_DIVISOR:    top_div = value[DIV_W-1:0];
      CFG_BOTTOM_RUN_DIVISOR: bottom_div = value[DIV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_word(input logic [PIX_W-1:0] pix);
    pending_pixels.push_back(pix);
    pixels_queued++;
  endtask

  // Queue count pixels, one texture per row-sized chunk.
  task automatic queue_pixels(input int unsigned count);
    int unsigned      chunk;
    int unsigned      run;
    texture_e         texture;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] v;
    while (count != 0) begin
      chunk = (count < frame_cols()) ? count : frame_cols();
      count -= chunk;
      texture = texture_e'($urandom_range(0, 4));
      a = PIX_W'($urandom);
      b = $urandom_range(0, 1) ? ~a : PIX_W'($urandom);
      v = a;
      run = 0;
      for (int unsigned i = 0; i < chunk; i++) begin
        case (texture)
          ALTERNATE: v = i[0] ? b : a;
          TWO_LEVEL: v = $urandom_range(0, 1) ? b : a;
          RUNS: begin
            if (run == 0) begin
              v = $urandom_range(0, 1) ? b : PIX_W'($urandom);
              run = $urandom_range(1, chunk);
            end
            run--;
          end
          NOISE: v = PIX_W'($urandom);
          default: v = a;
        endcase
        queue_word(v);
      end
    end
  endtask

  // Wait until every queued word is taken and every frame result has come,
  // then give the back half time to empty before settings change.
  task automatic drain();
    while (pixels_accepted != pixels_queued || expected_bounds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [PIX_W-1:0] mixed_rows[12] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h05, 8'h05,
                                          8'h05, 8'h05, 8'h01, 8'h02, 8'h01, 8'h02};
    logic [PIX_W-1:0] quiet_rows[4] = '{8'hFF, 8'h00, 8'h00, 8'hFF};
    logic [PIX_W-1:0] run_rows[6] = '{8'h07, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B};
    int unsigned round;
    int unsigned random_pixels;
    int unsigned cols;
    int unsigned rows;
    int unsigned n;
    bit          big;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Three rows with zero divisors: rows zero and two qualify.
    write_reg(CFG_MIN_TRANSITIONS, CFG_DATA_W'(2));
    write_reg(CFG_COLS_IN_USE, CFG_DATA_W'(4));
    write_reg(CFG_ROWS_IN_USE, CFG_DATA_W'(3));
    write_reg(CFG_TOP_RUN_DIVISOR, CFG_DATA_W'(0));
    write_reg(CFG_BOTTOM_RUN_DIVISOR, CFG_DATA_W'(0));
    foreach (mixed_rows[i]) queue_word(mixed_rows[i]);
    drain();

    // One-pixel frame: zero column size saturates to one, and the only row
    // qualifies for the top search with a zero threshold.
    write_reg(CFG_MIN_TRANSITIONS, CFG_DATA_W'(0));
    write_reg(CFG_COLS_IN_USE, CFG_DATA_W'(0));
    write_reg(CFG_ROWS_IN_USE, CFG_DATA_W'(1));
    queue_word(8'h80);
    drain();

    // Highest threshold: nothing qualifies, so both bounds fall to defaults.
    write_reg(CFG_MIN_TRANSITIONS, CFG_DATA_W'(1023));
    write_reg(CFG_COLS_IN_USE, CFG_DATA_W'(2));
    write_reg(CFG_ROWS_IN_USE, CFG_DATA_W'(2));
    foreach (quiet_rows[i]) queue_word(quiet_rows[i]);
    drain();

    // Largest divisors: a single equal pair aborts the first row.
    write_reg(CFG_MIN_TRANSITIONS, CFG_DATA_W'(1));
    write_reg(CFG_COLS_IN_USE, CFG_DATA_W'(3));
    write_reg(CFG_TOP_RUN_DIVISOR, CFG_DATA_W'(15));
    write_reg(CFG_BOTTOM_RUN_DIVISOR, CFG_DATA_W'(15));
    foreach (run_rows[i]) queue_word(run_rows[i]);
    drain();

    // Random rounds. Each starts idle, possibly mid-frame, so new sizes can
    // cut short the row or frame in progress. Two rounds set a size past the
    // largest and send only part of a long row or frame, which the next
    // round cuts short; the rest keep frames small so results come often.
    round = 0;
    random_pixels = 0;
    while (random_pixels < 750) begin
      round++;
      big = (round == 3 || round == 8);
      if (big) begin
        write_reg(CFG_COLS_IN_USE, CFG_DATA_W'((round == 3) ? 2047 : 1));
        write_reg(CFG_ROWS_IN_USE, CFG_DATA_W'((round == 3) ? 1 : 2047));
      end else begin
        write_reg(CFG_COLS_IN_USE, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
                                               $urandom_range(0, 1) :
                                               $urandom_range(2, 8)));
        write_reg(CFG_ROWS_IN_USE, CFG_DATA_W'(($urandom_range(0, 9) == 0) ? 0 :
                                               $urandom_range(1, 6)));
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: n = $urandom_range(0, 4);
          6, 7:             n = $urandom_range(0, frame_cols());
          8:                n = 1023;
          default:          n = $urandom;
        endcase
        write_reg(CFG_MIN_TRANSITIONS, CFG_DATA_W'(n));
      end
      if ($urandom_range(0, 1)) write_reg(CFG_TOP_RUN_DIVISOR, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 1)) write_reg(CFG_BOTTOM_RUN_DIVISOR, CFG_DATA_W'($urandom));
      // Writes to indexes past the last register must change nothing.
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_BOTTOM_RUN_DIVISOR + CFG_IDX_W'($urandom_range(1, 3)),
                  CFG_DATA_W'($urandom));
      end

      cols = frame_cols();
      rows = frame_rows();
      if (big) begin
        // Part of a long row or frame; long runs meet the saturated size.
        n = $urandom_range(20, 120);
      end else begin
        // Finish the frame in progress under the new sizes first.
        n = (col_pos + 1 >= cols) ? 1 : cols - col_pos;
        if (row_pos + 1 < rows) n += (rows - 1 - row_pos) * cols;
        n += $urandom_range(0, 2) * cols * rows;
        // Some rounds end with a broken frame that the next round finishes.
        if (cols * rows > 1 && $urandom_range(0, 2) == 0) begin
          n += $urandom_range(1, cols * rows - 1);
        end
      end
      random_pixels += n;
      queue_pixels(n);
      drain();
    end

    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
